FILE: rtl/core/isp_pkg.sv
// isp_pkg: shared types, constants and helpers of the interpolating sample player
// used by isp_ctrl, isp_datapath and interpolating_sample_player; no dependencies
package isp_pkg;

   localparam int DEFAULT_SAMPLE_DEPTH  = 65536;
   localparam int DEFAULT_GUARD_SAMPLES = 4;

   localparam int ADDR_W  = 17;
   localparam int SMP_W   = 16;
   localparam int LVL_W   = 17;
   localparam int STEP_W  = 24;
   localparam int POS_W   = 33;
   localparam int FRAC_W  = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [LVL_W-1:0] UNITY = 17'd65536;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_NOTE_ON = 2'd1,
      OP_RENDER  = 2'd2,
      OP_STOP    = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PITCH_STEP    = 3'd0,
      CSR_SAMPLE_LENGTH = 3'd1,
      CSR_NOTE_GAIN     = 3'd2,
      CSR_STEREO_SOURCE = 3'd3,
      CSR_STEREO_OUTPUT = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INTERP,
      ST_SCALE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic load_we;
      logic note_on;
      logic stop;
      logic interp;
      logic scale;
      logic finish;
   } cmd_type;

   function automatic logic [SMP_W-1:0] sat16(input logic signed [19:0] v);
      logic [SMP_W-1:0] r;
      if (v > 20'sd32767) begin
         r = 16'h7fff;
      end else if (v < -20'sd32768) begin
         r = 16'h8000;
      end else begin
         r = v[SMP_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/isp_sample_mem.sv
// isp_sample_mem: one write port, two registered read ports sample memory
// no dependencies
module isp_sample_mem #(
   parameter int DEPTH = 65540,
   parameter int AW    = 17
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [15:0]   wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr0,
   input  logic [AW-1:0] raddr1,
   output logic [15:0]   rdata0,
   output logic [15:0]   rdata1
);

   logic [15:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata0 <= mem[raddr0];
         rdata1 <= mem[raddr1];
      end
   end

endmodule

FILE: rtl/core/isp_ctrl.sv
// isp_ctrl: tick sequencer and result handshake of the sample player
// depends on isp_pkg
module isp_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_op,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output isp_pkg::cmd_type cmd
);
   import isp_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (op_type'(req_op))
                  OP_LOAD:    cmd.load_we = 1'b1;
                  OP_NOTE_ON: cmd.note_on = 1'b1;
                  OP_STOP:    cmd.stop    = 1'b1;
                  OP_RENDER: begin
                     cmd.capture = 1'b1;
                     state_in    = ST_INTERP;
                  end
                  default: ;
               endcase
            end
         end
         ST_INTERP: begin
            cmd.interp = 1'b1;
            state_in   = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            // result register must be free or draining this cycle
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.finish | (rsp_valid_ff & ~rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;

   a_finish_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten before transfer");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("input taken during a tick");

   a_capture_starts_tick: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == ST_INTERP))
      else $error("render tick did not start");

   a_result_after_tick: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished tick without result");

endmodule

FILE: rtl/core/isp_datapath.sv
// isp_datapath: sample memories, play position, interpolation, gain and mix
// depends on isp_pkg and isp_sample_mem
module isp_datapath #(
   parameter int SAMPLE_DEPTH  = isp_pkg::DEFAULT_SAMPLE_DEPTH,
   parameter int GUARD_SAMPLES = isp_pkg::DEFAULT_GUARD_SAMPLES
) (
   input  logic                               clock,
   input  logic                               reset,
   input  isp_pkg::cmd_type                   cmd,
   input  logic                               csr_we,
   input  logic [isp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [isp_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [isp_pkg::ADDR_W-1:0]         req_load_address,
   input  logic signed [isp_pkg::SMP_W-1:0]   req_load_left,
   input  logic signed [isp_pkg::SMP_W-1:0]   req_load_right,
   input  logic [isp_pkg::LVL_W-1:0]          req_envelope_level,
   input  logic signed [isp_pkg::SMP_W-1:0]   req_mix_left_in,
   input  logic signed [isp_pkg::SMP_W-1:0]   req_mix_right_in,
   output logic signed [isp_pkg::SMP_W-1:0]   rsp_out_left,
   output logic signed [isp_pkg::SMP_W-1:0]   rsp_out_right,
   output logic                               rsp_note_ended
);
   import isp_pkg::*;

   localparam int          MEM_DEPTH   = SAMPLE_DEPTH + GUARD_SAMPLES;
   localparam int          AW          = $clog2(MEM_DEPTH);
   localparam logic [31:0] MEM_DEPTH_W = 32'(MEM_DEPTH);

   // configuration
   logic [STEP_W-1:0] pitch_step_ff;
   logic [ADDR_W-1:0] sample_length_ff;
   logic [LVL_W-1:0]  note_gain_ff;
   logic              stereo_source_ff;
   logic              stereo_output_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_step_ff    <= 24'd65536;
         sample_length_ff <= '0;
         note_gain_ff     <= UNITY;
         stereo_source_ff <= 1'b0;
         stereo_output_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_PITCH_STEP:    pitch_step_ff    <= csr_wdata;
            CSR_SAMPLE_LENGTH: sample_length_ff <= csr_wdata[ADDR_W-1:0];
            CSR_NOTE_GAIN:     note_gain_ff     <= csr_wdata[LVL_W-1:0];
            CSR_STEREO_SOURCE: stereo_source_ff <= csr_wdata[0];
            CSR_STEREO_OUTPUT: stereo_output_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // voice state
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             playing_ff, playing_in;
   logic [POS_W:0]   pos_sum;
   logic             ended;

   assign pos_sum = {1'b0, pos_ff} + {{(POS_W+1-STEP_W){1'b0}}, pitch_step_ff};
   assign ended   = pos_sum[POS_W-1:0] > {sample_length_ff, 16'd0};

   always_comb begin
      pos_in     = pos_ff;
      playing_in = playing_ff;
      if (cmd.note_on) begin
         pos_in     = '0;
         playing_in = 1'b1;
      end else if (cmd.stop) begin
         playing_in = 1'b0;
      end else if (cmd.finish && playing_ff) begin
         pos_in = pos_sum[POS_W-1:0];
         if (ended) begin
            playing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         playing_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         playing_ff <= playing_in;
      end
   end

   // sample memories
   logic [31:0]   waddr_ext, raddr0_ext, raddr1_ext;
   logic          load_en;
   logic [15:0]   rd0_l, rd1_l, rd0_r, rd1_r;

   assign waddr_ext  = {{(32-ADDR_W){1'b0}}, req_load_address};
   assign raddr0_ext = {{(32-ADDR_W){1'b0}}, pos_ff[POS_W-1:FRAC_W]};
   assign raddr1_ext = raddr0_ext + 32'd1;
   assign load_en    = cmd.load_we && (waddr_ext < MEM_DEPTH_W);

   isp_sample_mem #(.DEPTH(MEM_DEPTH), .AW(AW)) u_left_mem (
      .clock  (clock),
      .we     (load_en),
      .waddr  (waddr_ext[AW-1:0]),
      .wdata  (req_load_left),
      .re     (cmd.capture),
      .raddr0 (raddr0_ext[AW-1:0]),
      .raddr1 (raddr1_ext[AW-1:0]),
      .rdata0 (rd0_l),
      .rdata1 (rd1_l)
   );

   isp_sample_mem #(.DEPTH(MEM_DEPTH), .AW(AW)) u_right_mem (
      .clock  (clock),
      .we     (load_en),
      .waddr  (waddr_ext[AW-1:0]),
      .wdata  (req_load_right),
      .re     (cmd.capture),
      .raddr0 (raddr0_ext[AW-1:0]),
      .raddr1 (raddr1_ext[AW-1:0]),
      .rdata0 (rd0_r),
      .rdata1 (rd1_r)
   );

   // capture stage: gain times envelope, mix inputs, read range flags
   logic [LVL_W-1:0]        gain_sat, env_sat, g_ff;
   logic [33:0]             g_prod, g_round;
   logic signed [SMP_W-1:0] mix_l_ff, mix_r_ff;
   logic                    in0_ff, in1_ff;

   assign gain_sat = (note_gain_ff > UNITY) ? UNITY : note_gain_ff;
   assign env_sat  = (req_envelope_level > UNITY) ? UNITY : req_envelope_level;
   assign g_prod   = {17'd0, gain_sat} * {17'd0, env_sat};
   assign g_round  = g_prod + 34'd32768;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         g_ff     <= g_round[32:16];
         mix_l_ff <= req_mix_left_in;
         mix_r_ff <= req_mix_right_in;
         in0_ff   <= raddr0_ext < MEM_DEPTH_W;
         in1_ff   <= raddr1_ext < MEM_DEPTH_W;
      end
   end

   // interpolation stage
   logic signed [SMP_W-1:0] s0_l, s1_l, s0_r, s1_r;
   logic signed [16:0]      diff_l, diff_r, frac_s;
   logic signed [33:0]      a_l, a_r;
   logic signed [31:0]      al_ff, ar_ff;

   assign s0_l   = in0_ff ? $signed(rd0_l) : 16'sd0;
   assign s1_l   = in1_ff ? $signed(rd1_l) : 16'sd0;
   assign s0_r   = in0_ff ? $signed(rd0_r) : 16'sd0;
   assign s1_r   = in1_ff ? $signed(rd1_r) : 16'sd0;
   assign diff_l = {s1_l[15], s1_l} - {s0_l[15], s0_l};
   assign diff_r = {s1_r[15], s1_r} - {s0_r[15], s0_r};
   assign frac_s = $signed({1'b0, pos_ff[FRAC_W-1:0]});
   assign a_l    = diff_l * frac_s + $signed({{2{s0_l[15]}}, s0_l, 16'd0});
   assign a_r    = diff_r * frac_s + $signed({{2{s0_r[15]}}, s0_r, 16'd0});

   always_ff @(posedge clock) begin
      if (cmd.interp) begin
         al_ff <= a_l[31:0];
         ar_ff <= stereo_source_ff ? a_r[31:0] : a_l[31:0];
      end
   end

   // scaling stage
   logic signed [49:0] c_l, c_r, cl_ff, cr_ff;
   logic signed [17:0] g_s;

   assign g_s = $signed({1'b0, g_ff});
   assign c_l = al_ff * g_s;
   assign c_r = ar_ff * g_s;

   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         cl_ff <= c_l;
         cr_ff <= c_r;
      end
   end

   // rounding, mix and saturation
   logic signed [50:0] sum_l, sum_r;
   logic signed [51:0] sum_m;
   logic signed [19:0] tot_l, tot_r, tot_m, mix_l_x, mix_r_x;

   assign sum_l   = {cl_ff[49], cl_ff} + (51'sd1 <<< 31);
   assign sum_r   = {cr_ff[49], cr_ff} + (51'sd1 <<< 31);
   assign sum_m   = {{2{cl_ff[49]}}, cl_ff} + {{2{cr_ff[49]}}, cr_ff} + (52'sd1 <<< 32);
   assign mix_l_x = {{4{mix_l_ff[15]}}, mix_l_ff};
   assign mix_r_x = {{4{mix_r_ff[15]}}, mix_r_ff};
   assign tot_l   = mix_l_x + {sum_l[50], sum_l[50:32]};
   assign tot_r   = mix_r_x + {sum_r[50], sum_r[50:32]};
   assign tot_m   = mix_l_x + {sum_m[51], sum_m[51:33]};

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (!playing_ff) begin
            rsp_out_left   <= mix_l_ff;
            rsp_out_right  <= mix_r_ff;
            rsp_note_ended <= 1'b0;
         end else begin
            rsp_out_left   <= stereo_output_ff ? sat16(tot_l) : sat16(tot_m);
            rsp_out_right  <= stereo_output_ff ? sat16(tot_r) : mix_r_ff;
            rsp_note_ended <= ended;
         end
      end
   end

endmodule

FILE: rtl/core/interpolating_sample_player.sv
// interpolating_sample_player: top level of the one-voice sample player
// depends on isp_pkg, isp_ctrl, isp_datapath and isp_sample_mem
//
//   channel   direction  handshake             payload
//   req_      in         req_valid/req_ready   op, load address and samples, envelope, mix
//   rsp_      out        rsp_valid/rsp_ready   out_left, out_right, note_ended
//   csr_      in         csr_valid/csr_ready   csr_index, csr_wdata
//
// load, note-on and hard stop act as the request is taken and leave the block idle
// a render tick runs capture and memory read, interpolate, gain, then round and mix
//   (two multiplier stages follow the registered memory read)
// the result register lets the next item transfer while a result waits;
//   a tick holds in its finish state until that register is free or draining
// reset clears control, configuration and position; data registers and sample memories are not cleared
module interpolating_sample_player #(
   parameter int SAMPLE_DEPTH  = isp_pkg::DEFAULT_SAMPLE_DEPTH,
   parameter int GUARD_SAMPLES = isp_pkg::DEFAULT_GUARD_SAMPLES
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_op,
   input  logic [isp_pkg::ADDR_W-1:0]         req_load_address,
   input  logic signed [isp_pkg::SMP_W-1:0]   req_load_left,
   input  logic signed [isp_pkg::SMP_W-1:0]   req_load_right,
   input  logic [isp_pkg::LVL_W-1:0]          req_envelope_level,
   input  logic signed [isp_pkg::SMP_W-1:0]   req_mix_left_in,
   input  logic signed [isp_pkg::SMP_W-1:0]   req_mix_right_in,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [isp_pkg::SMP_W-1:0]   rsp_out_left,
   output logic signed [isp_pkg::SMP_W-1:0]   rsp_out_right,
   output logic                               rsp_note_ended,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [isp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [isp_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import isp_pkg::*;

   cmd_type cmd;

   assign csr_ready = 1'b1;

   isp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   isp_datapath #(
      .SAMPLE_DEPTH  (SAMPLE_DEPTH),
      .GUARD_SAMPLES (GUARD_SAMPLES)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .csr_we             (csr_valid),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_load_address   (req_load_address),
      .req_load_left      (req_load_left),
      .req_load_right     (req_load_right),
      .req_envelope_level (req_envelope_level),
      .req_mix_left_in    (req_mix_left_in),
      .req_mix_right_in   (req_mix_right_in),
      .rsp_out_left       (rsp_out_left),
      .rsp_out_right      (rsp_out_right),
      .rsp_note_ended     (rsp_note_ended)
   );

endmodule
